>>> rtl/cma_pkg.sv
// Shared constants, types and widths for the centered moving average block.
package cma_pkg;

    // Sample and window sizing.
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WINDOW  = 64;
    localparam int CFG_W       = 7;
    localparam logic [CFG_W-1:0] WIN_RESET = CFG_W'(5);

    // Derived widths for counts, ring addresses and signed flush indexes.
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int ADDR_W = $clog2(MAX_WINDOW);
    localparam int IDX_W  = CNT_W + 1;
    localparam int WIN_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Running sum and its magnitude.
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int MAG_W = SAMPLE_BITS - 1 + CNT_W;

    // Reciprocal scaling: the shift is large enough that the rounded-up
    // reciprocal gives the exact truncated quotient for every sum and count.
    localparam int RCP_SHIFT = SAMPLE_BITS - 1 + 2 * CNT_W;
    localparam int RCP_W     = RCP_SHIFT + 1;
    localparam int PROD_W    = MAG_W + RCP_W;

    // Output queue sizing.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Division request from the sequencer to the divider.
    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        held;
        logic                    last;
    } div_req_t;

    // Finished mean word from the divider to the output queue.
    typedef struct packed {
        logic                          valid;
        logic signed [SAMPLE_BITS-1:0] mean;
        logic                          last;
    } div_res_t;

endpackage

>>> rtl/cma_div.sv
// Two-stage reciprocal divider: window sum divided by sample count, truncated toward zero.
module cma_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  cma_pkg::div_req_t   req,
    output cma_pkg::div_res_t   res,
    output logic [1:0]          inflight
);

    // Reciprocal table, entry d-1 holds ceil(2^RCP_SHIFT / d).
    logic [cma_pkg::RCP_W-1:0] rcp_table [cma_pkg::MAX_WINDOW];

    for (genvar g = 1; g <= cma_pkg::MAX_WINDOW; g++)
    begin : g_rcp
        localparam logic [63:0] RCP_VAL =
            ((64'd1 << cma_pkg::RCP_SHIFT) + 64'(g) - 64'd1) / 64'(g);
        assign rcp_table[g-1] = cma_pkg::RCP_W'(RCP_VAL);
    end

    logic                                 s1_valid_reg;
    logic                                 s1_neg_reg;
    logic                                 s1_last_reg;
    logic [cma_pkg::MAG_W-1:0]            s1_mag_reg;
    logic [cma_pkg::RCP_W-1:0]            s1_rcp_reg;
    logic                                 s2_valid_reg;
    logic                                 s2_neg_reg;
    logic                                 s2_last_reg;
    logic [cma_pkg::PROD_W-1:0]           s2_prod_reg;
    logic signed [cma_pkg::SUM_W-1:0]     abs_sum;
    logic [cma_pkg::ADDR_W-1:0]           rcp_idx;
    logic [cma_pkg::SAMPLE_BITS-1:0]      q_mag;

    // Magnitude of the sum and table index of the count.
    assign abs_sum = req.sum[cma_pkg::SUM_W-1] ? -req.sum : req.sum;
    assign rcp_idx = cma_pkg::ADDR_W'(req.held - cma_pkg::CNT_W'(1));

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage one: sign, magnitude and reciprocal; stage two: the product.
    always_ff @(posedge clk)
    begin
        s1_neg_reg  <= req.sum[cma_pkg::SUM_W-1];
        s1_last_reg <= req.last;
        s1_mag_reg  <= cma_pkg::MAG_W'(abs_sum);
        s1_rcp_reg  <= rcp_table[rcp_idx];
        s2_neg_reg  <= s1_neg_reg;
        s2_last_reg <= s1_last_reg;
        s2_prod_reg <= cma_pkg::PROD_W'(s1_mag_reg) * cma_pkg::PROD_W'(s1_rcp_reg);
    end

    // Scale back down and restore the sign.
    assign q_mag     = s2_prod_reg[cma_pkg::RCP_SHIFT +: cma_pkg::SAMPLE_BITS];
    assign res.valid = s2_valid_reg;
    assign res.mean  = s2_neg_reg ? -$signed(q_mag) : $signed(q_mag);
    assign res.last  = s2_last_reg;
    assign inflight  = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg};

endmodule

>>> rtl/cma_outq.sv
// Small output queue holding finished mean words until the consumer takes them.
module cma_outq
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cma_pkg::div_res_t                   wr,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic signed [cma_pkg::SAMPLE_BITS-1:0] mean_value,
    output logic                                last_result,
    output logic [cma_pkg::QCNT_W-1:0]          count
);

    logic signed [cma_pkg::SAMPLE_BITS-1:0] q_mean_reg [cma_pkg::QDEPTH];
    logic                                   q_last_reg [cma_pkg::QDEPTH];
    logic [cma_pkg::QPTR_W-1:0]             wr_ptr_reg;
    logic [cma_pkg::QPTR_W-1:0]             rd_ptr_reg;
    logic [cma_pkg::QCNT_W-1:0]             count_reg;
    logic                                   pop;

    assign out_valid   = (count_reg != '0);
    assign pop         = out_valid && !out_stall;
    assign mean_value  = q_mean_reg[rd_ptr_reg];
    assign last_result = q_last_reg[rd_ptr_reg];
    assign count       = count_reg;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr.valid)
                wr_ptr_reg <= wr_ptr_reg + cma_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + cma_pkg::QPTR_W'(1);
            if (wr.valid && !pop)
                count_reg <= count_reg + cma_pkg::QCNT_W'(1);
            else if (!wr.valid && pop)
                count_reg <= count_reg - cma_pkg::QCNT_W'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            q_mean_reg[wr_ptr_reg] <= wr.mean;
            q_last_reg[wr_ptr_reg] <= wr.last;
        end
    end

endmodule

>>> rtl/centered_moving_average_unit.sv
// Centered moving average: sample ring, running sum sequencer, divider and output queue.
//
//  channel  | direction | handshake           | word
//  ---------+-----------+---------------------+---------------------------------
//  cfg      | in        | cfg_valid/cfg_ready | window_length
//  in       | in        | in_valid/in_stall   | sample, last_sample
//  out      | out       | out_valid/out_stall | mean_value, last_result
//
// A sample passes three steps: ring write plus oldest-entry read, sum update, mean issue.
// A record's final sample adds a flush step per look-ahead position, emitted or skipped,
// and a flush and a drop step per dropped sample, set by the single read port of the ring;
// the divider adds its s1 and s2 pipeline registers.
// Reset clears the sum, counts and ring head and sets the window to 5; ring contents
// are not cleared. A mean waits for a queue slot, so out_stall backs up into in_stall.
module centered_moving_average_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cma_pkg::CFG_W-1:0]              window_length,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [cma_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   last_sample,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [cma_pkg::SAMPLE_BITS-1:0] mean_value,
    output logic                                   last_result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_EMIT  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_DROP  = 3'd4;

    logic [2:0]                             state_reg, state_next;
    logic [cma_pkg::CFG_W-1:0]              win_reg, win_next;
    logic signed [cma_pkg::SUM_W-1:0]       sum_reg, sum_next;
    logic [cma_pkg::CNT_W-1:0]              held_reg, held_next;
    logic [cma_pkg::ADDR_W-1:0]             head_reg, head_next;
    logic                                   drop_reg, drop_next;
    logic signed [cma_pkg::SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic                                   last_reg, last_next;
    logic signed [cma_pkg::IDX_W-1:0]       fl_idx_reg, fl_idx_next;
    logic signed [cma_pkg::IDX_W-1:0]       fl_end_reg, fl_end_next;
    logic [cma_pkg::CNT_W-1:0]              oldest_reg, oldest_next;

    // Sample ring.
    logic signed [cma_pkg::SAMPLE_BITS-1:0] ring [cma_pkg::MAX_WINDOW];
    logic signed [cma_pkg::SAMPLE_BITS-1:0] ram_rdata_reg;
    logic                                   ram_we;
    logic [cma_pkg::ADDR_W-1:0]             ram_raddr;

    logic [cma_pkg::WIN_W-1:0]              win_ext;
    logic [cma_pkg::CNT_W-1:0]              win_eff;
    logic [cma_pkg::CNT_W-1:0]              back;
    logic [cma_pkg::CNT_W-1:0]              ahead;
    logic [cma_pkg::IDX_W-1:0]              head_ext;
    logic [cma_pkg::IDX_W-1:0]              held_ext;
    logic [cma_pkg::ADDR_W-1:0]             oldest_addr;
    logic signed [cma_pkg::IDX_W-1:0]       lo_idx;
    logic                                   room;
    logic                                   need_emit;

    cma_pkg::div_req_t                      req;
    cma_pkg::div_res_t                      res;
    logic [1:0]                             inflight;
    logic [cma_pkg::QCNT_W-1:0]             q_count;

    // Effective window and its split around the center.
    assign win_ext = cma_pkg::WIN_W'(win_reg);
    assign win_eff = (win_ext == '0) ? cma_pkg::CNT_W'(1) :
                     (win_ext > cma_pkg::WIN_W'(cma_pkg::MAX_WINDOW)) ?
                     cma_pkg::CNT_W'(cma_pkg::MAX_WINDOW) : cma_pkg::CNT_W'(win_ext);
    assign back    = win_eff >> 1;
    assign ahead   = (win_eff - cma_pkg::CNT_W'(1)) >> 1;

    // Ring position of the oldest held sample.
    assign head_ext    = cma_pkg::IDX_W'(head_reg);
    assign held_ext    = cma_pkg::IDX_W'(held_reg);
    assign oldest_addr = (head_ext >= held_ext) ?
                         cma_pkg::ADDR_W'(head_ext - held_ext) :
                         cma_pkg::ADDR_W'(head_ext + cma_pkg::IDX_W'(cma_pkg::MAX_WINDOW)
                                          - held_ext);

    // Lower edge of the window of the flushed output.
    assign lo_idx = fl_idx_reg - $signed(cma_pkg::IDX_W'(back));

    // A mean may be issued only when a queue slot is sure to be free.
    assign room = (q_count + cma_pkg::QCNT_W'(inflight)) < cma_pkg::QCNT_W'(cma_pkg::QDEPTH);
    assign need_emit = (held_reg >= ahead + cma_pkg::CNT_W'(1));

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        win_next    = win_reg;
        sum_next    = sum_reg;
        held_next   = held_reg;
        head_next   = head_reg;
        drop_next   = drop_reg;
        smp_next    = smp_reg;
        last_next   = last_reg;
        fl_idx_next = fl_idx_reg;
        fl_end_next = fl_end_reg;
        oldest_next = oldest_reg;
        ram_we      = 1'b0;
        ram_raddr   = oldest_addr;
        req         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    win_next  = window_length;
                    sum_next  = '0;
                    held_next = '0;
                    head_next = '0;
                end
                else if (in_valid)
                begin
                    ram_we     = 1'b1;
                    drop_next  = (held_reg == win_eff);
                    smp_next   = sample;
                    last_next  = last_sample;
                    state_next = ST_UPD;
                end
            end

            ST_UPD:
            begin
                sum_next = sum_reg + cma_pkg::SUM_W'(smp_reg)
                           - (drop_reg ? cma_pkg::SUM_W'(ram_rdata_reg) : '0);
                if (!drop_reg)
                    held_next = held_reg + cma_pkg::CNT_W'(1);
                head_next = (head_reg == cma_pkg::ADDR_W'(cma_pkg::MAX_WINDOW - 1)) ?
                            '0 : head_reg + cma_pkg::ADDR_W'(1);
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (!need_emit || room)
                begin
                    if (need_emit)
                    begin
                        req.valid = 1'b1;
                        req.sum   = sum_reg;
                        req.held  = held_reg;
                        req.last  = last_reg && (ahead == '0);
                    end
                    if (last_reg && (ahead != '0))
                    begin
                        fl_idx_next = $signed(held_ext) - $signed(cma_pkg::IDX_W'(ahead));
                        fl_end_next = $signed(held_ext - cma_pkg::IDX_W'(1));
                        oldest_next = '0;
                        state_next  = ST_FLUSH;
                    end
                    else
                    begin
                        if (last_reg)
                        begin
                            sum_next  = '0;
                            held_next = '0;
                            head_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FLUSH:
            begin
                // Outputs before the record start are skipped.
                if (fl_idx_reg < 0)
                    fl_idx_next = fl_idx_reg + cma_pkg::IDX_W'(1);
                else if ($signed({1'b0, oldest_reg}) < lo_idx)
                    state_next = ST_DROP;
                else if (room)
                begin
                    req.valid = 1'b1;
                    req.sum   = sum_reg;
                    req.held  = held_reg;
                    req.last  = (fl_idx_reg == fl_end_reg);
                    if (fl_idx_reg == fl_end_reg)
                    begin
                        sum_next   = '0;
                        held_next  = '0;
                        head_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        fl_idx_next = fl_idx_reg + cma_pkg::IDX_W'(1);
                end
            end

            ST_DROP:
            begin
                sum_next    = sum_reg - cma_pkg::SUM_W'(ram_rdata_reg);
                held_next   = held_reg - cma_pkg::CNT_W'(1);
                oldest_next = oldest_reg + cma_pkg::CNT_W'(1);
                state_next  = ST_FLUSH;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            win_reg    <= cma_pkg::WIN_RESET;
            sum_reg    <= '0;
            held_reg   <= '0;
            head_reg   <= '0;
            drop_reg   <= 1'b0;
            last_reg   <= 1'b0;
            fl_idx_reg <= '0;
            fl_end_reg <= '0;
            oldest_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            win_reg    <= win_next;
            sum_reg    <= sum_next;
            held_reg   <= held_next;
            head_reg   <= head_next;
            drop_reg   <= drop_next;
            last_reg   <= last_next;
            fl_idx_reg <= fl_idx_next;
            fl_end_reg <= fl_end_next;
            oldest_reg <= oldest_next;
        end
    end

    // Sample payload register.
    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
    end

    // Ring memory: read-first, so a write to the entry being read returns the old sample.
    always_ff @(posedge clk)
    begin
        if (ram_we)
            ring[head_reg] <= sample;
        ram_rdata_reg <= ring[ram_raddr];
    end

    cma_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .res      (res),
        .inflight (inflight)
    );

    cma_outq u_outq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (res),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .mean_value  (mean_value),
        .last_result (last_result),
        .count       (q_count)
    );

    // The queue plus the divider stages never hold more words than the queue has slots.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count + cma_pkg::QCNT_W'(inflight)) <= cma_pkg::QCNT_W'(cma_pkg::QDEPTH))
        else $error("output queue overcommitted");

    // The held sample count stays within the effective window.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= win_eff)
        else $error("held count beyond window");

    // An accepted sample always moves on to the sum update.
    a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_UPD))
        else $error("accepted sample not processed");

    // A drop is only taken while samples are held.
    a_drop_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DROP) |-> (held_reg != '0))
        else $error("drop with empty window");

endmodule
